/* rtl/core/srtc_pkg.sv */
// Shared types and constants for the serial real-time clock block.
// Used by the top level and its port checker.
// No dependencies.
package srtc_pkg;

  // Default number of parameter RAM bytes.
  localparam int RamDepthDef = 256;

  // Widths of the configuration port.
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_XPRAM = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_START = 8'd1;

  // Input action codes.
  localparam logic [1:0] ACT_CLOCK  = 2'd0;
  localparam logic [1:0] ACT_ENABLE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // Fault codes reported with each result word.
  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_WR_UNKNOWN = 2'd1;
  localparam logic [1:0] FAULT_RD_UNKNOWN = 2'd2;
  localparam logic [1:0] FAULT_ABORT      = 2'd3;

  // Command decoder constants.
  localparam logic [7:0] ExtCmdMask  = 8'h78;
  localparam logic [7:0] ExtCmdMatch = 8'h38;
  localparam logic [7:0] Group1Xp    = 8'h10;
  localparam logic [7:0] Group1Std   = 8'h00;
  localparam logic [7:0] Group2Xp    = 8'h08;
  localparam logic [7:0] Group2Std   = 8'h10;

  // Register selector codes inside a one-byte command.
  localparam logic [4:0] SEL_TEST    = 5'd12;
  localparam logic [4:0] SEL_PROTECT = 5'd13;

  // Command decoder state.
  typedef enum logic [1:0] {
    MODE_CMD       = 2'd0,
    MODE_WRITE     = 2'd1,
    MODE_EXT_ADDR  = 2'd2,
    MODE_EXT_WRITE = 2'd3
  } mode_e;

  // One input word.
  typedef struct packed {
    logic [1:0] action;
    logic       clock_level;
    logic       chip_disabled;
    logic       data_in;
    logic [7:0] seconds_elapsed;
  } in_t;

  // One result word.
  typedef struct packed {
    logic       data_line_out;
    logic       driving;
    logic       second_pulse;
    logic [1:0] fault_code;
  } out_t;

endpackage

/* rtl/core/srtc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the parameter RAM bytes of the serial clock block. No dependencies.
module srtc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/serial_rtc_with_parameter_ram_top.sv */
// Results are registered in the output register, or in the skid one on a stall.
// Throughput: one input word per cycle; in_ready_o drops only while both the
// output register and the skid register hold words, since each RAM
// port is used at most once per word and read data is forwarded.
// Reset (asynchronous, active low) resets all control state and the per-byte
// valid bits, so unwritten RAM bytes read as zero; there is no clearing pass.
// Depends on srtc_pkg and srtc_ram.
module serial_rtc_with_parameter_ram_top #(
  parameter int RAM_DEPTH = srtc_pkg::RamDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srtc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output srtc_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [srtc_pkg::CfgDataW-1:0] cfg_data_i
);

  import srtc_pkg::*;

  localparam int         AddrW     = $clog2(RAM_DEPTH);
  localparam logic [8:0] DepthLim  = 9'(RAM_DEPTH);

  // Control and shift state.
  mode_e       mode_q, mode_d;
  logic [7:0]  sb_q, sb_d;
  logic [2:0]  bc_q, bc_d;
  logic        oa_q, oa_d;
  logic        on_q, on_d;
  logic        locked_q, locked_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  ext_q, ext_d;
  logic [31:0] sec_q, sec_d;
  logic        line_q, line_d;
  logic        xp_q, xp_d;
  logic        pend_q, pend_d;
  logic        rd_ok_q, rd_ok_d;
  logic [RAM_DEPTH-1:0] vld_q;

  // Output register and skid register.
  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q, res;

  // RAM port signals.
  logic             ram_we, ram_re;
  logic [7:0]       ram_waddr8, ram_raddr8;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             rd_in_range, wr_in_range;

  // Shared decode signals.
  logic       in_acc, cfg_acc, clk_evt, abort, byte_done, is_ext;
  logic [2:0] bc_n;
  logic [7:0] sb_eff, sb_in;

  assign in_ready_o  = ~skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // Read data from the previous word's RAM access replaces the shift byte.
  assign sb_eff    = pend_q ? (rd_ok_q ? ram_rdata : 8'h00) : sb_q;
  assign sb_in     = {sb_eff[6:0], in_data_i.data_in};
  assign bc_n      = bc_q - 3'd1;
  assign clk_evt   = in_acc && (in_data_i.action == ACT_CLOCK) &&
                     !in_data_i.chip_disabled && in_data_i.clock_level;
  assign byte_done = clk_evt && !on_q && (bc_n == 3'd0);
  assign abort     = in_acc && (in_data_i.action == ACT_ENABLE) &&
                     in_data_i.chip_disabled;
  assign is_ext    = xp_q && ((sb_in & ExtCmdMask) == ExtCmdMatch);

  assign rd_in_range = {1'b0, ram_raddr8} < DepthLim;
  assign wr_in_range = {1'b0, ram_waddr8} < DepthLim;

  // Next state of the command decoder.
  always_comb begin
    mode_d = mode_q;
    if (abort) begin
      mode_d = MODE_CMD;
    end else if (byte_done) begin
      unique case (mode_q)
        MODE_CMD: begin
          if (is_ext) begin
            mode_d = MODE_EXT_ADDR;
          end else if (sb_in[7]) begin
            mode_d = MODE_CMD;
          end else begin
            mode_d = MODE_WRITE;
          end
        end
        MODE_WRITE:     mode_d = MODE_CMD;
        MODE_EXT_ADDR:  mode_d = held_q[7] ? MODE_CMD : MODE_EXT_WRITE;
        MODE_EXT_WRITE: mode_d = MODE_CMD;
        default:        mode_d = MODE_CMD;
      endcase
    end
  end

  // Datapath: shifting, register access, RAM requests, ticks and config.
  always_comb begin
    logic [7:0] cmd;
    logic [4:0] sel;
    logic [7:0] g1;
    logic [7:0] g2;
    logic [7:0] reg_addr;
    logic       do_write;
    logic       do_read;

    sb_d      = sb_eff;
    bc_d      = bc_q;
    oa_d      = oa_q;
    on_d      = on_q;
    locked_d  = locked_q;
    held_d    = held_q;
    ext_d     = ext_q;
    sec_d     = sec_q;
    line_d    = line_q;
    xp_d      = xp_q;
    pend_d    = 1'b0;
    rd_ok_d   = 1'b0;
    do_write  = 1'b0;
    do_read   = 1'b0;
    ram_waddr8 = 8'h00;
    ram_raddr8 = 8'h00;
    ram_wdata  = sb_in;
    res.fault_code   = FAULT_NONE;
    res.second_pulse = 1'b0;

    // One-byte command register decode.
    cmd      = (mode_q == MODE_CMD) ? sb_in : held_q;
    sel      = cmd[6:2];
    g1       = xp_q ? Group1Xp : Group1Std;
    g2       = xp_q ? Group2Xp : Group2Std;
    reg_addr = sel[4] ? (g1 + {4'b0000, sel[3:0]}) : (g2 + {6'b000000, sel[1:0]});

    if (clk_evt) begin
      oa_d = on_q;
      bc_d = bc_n;
      if (on_q) begin
        // Read-out phase: drive the next bit, MSB first.
        line_d = sb_eff[bc_n];
        if (bc_n == 3'd0) begin
          on_d = 1'b0;
        end
      end else begin
        sb_d = sb_in;
        if (bc_n == 3'd0) begin
          unique case (mode_q)
            MODE_CMD: begin
              if (is_ext) begin
                held_d = sb_in;
              end else if (sb_in[7]) begin
                on_d = 1'b1;
                if (!sel[4] && !sel[3]) begin
                  sb_d = sec_q[{sel[1:0], 3'b000} +: 8];
                end else if (sel[4] || !sel[2]) begin
                  ram_raddr8 = reg_addr;
                  do_read    = 1'b1;
                end else begin
                  sb_d           = 8'h00;
                  res.fault_code = FAULT_RD_UNKNOWN;
                end
              end else begin
                held_d = sb_in;
              end
            end
            MODE_WRITE: begin
              if (!sel[4] && !sel[3]) begin
                if (!locked_q) begin
                  sec_d[{sel[1:0], 3'b000} +: 8] = sb_in;
                end
              end else if (sel[4] || !sel[2]) begin
                ram_waddr8 = reg_addr;
                do_write   = 1'b1;
              end else if (sel == SEL_PROTECT) begin
                locked_d = sb_in[7];
              end else if (sel != SEL_TEST) begin
                res.fault_code = FAULT_WR_UNKNOWN;
              end
            end
            MODE_EXT_ADDR: begin
              ext_d = {held_q[2:0], sb_in[6:2]};
              if (held_q[7]) begin
                ram_raddr8 = {held_q[2:0], sb_in[6:2]};
                do_read    = 1'b1;
                on_d       = 1'b1;
              end
            end
            MODE_EXT_WRITE: begin
              ram_waddr8 = ext_q;
              do_write   = 1'b1;
            end
            default: begin
              sb_d = sb_in;
            end
          endcase
        end
      end
    end else if (abort) begin
      // Enable dropped: abandon the transfer.
      if (bc_q != 3'd0) begin
        res.fault_code = FAULT_ABORT;
      end
      oa_d = 1'b0;
      on_d = 1'b0;
      sb_d = 8'h00;
      bc_d = 3'd0;
    end else if (in_acc && (in_data_i.action == ACT_TICK) &&
                 (in_data_i.seconds_elapsed != 8'h00)) begin
      sec_d            = sec_q + {24'h000000, in_data_i.seconds_elapsed};
      res.second_pulse = 1'b1;
    end

    // A RAM read lands next cycle and is forwarded into the shift byte.
    if (do_read) begin
      pend_d  = 1'b1;
      rd_ok_d = rd_in_range && vld_q[ram_raddr8[AddrW-1:0]];
    end

    // Configuration writes.
    if (cfg_acc) begin
      if (cfg_index_i == CFG_XPRAM) begin
        xp_d = cfg_data_i[0];
      end else if (cfg_index_i == CFG_START) begin
        sec_d = cfg_data_i;
      end
    end

    ram_re = do_read;
    ram_we = do_write && !locked_q && wr_in_range;

    res.data_line_out = line_d;
    res.driving       = oa_d;
  end

  // Parameter RAM.
  srtc_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr8[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr8[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CMD;
      sb_q     <= 8'h00;
      bc_q     <= 3'd0;
      oa_q     <= 1'b0;
      on_q     <= 1'b0;
      locked_q <= 1'b0;
      held_q   <= 8'h00;
      ext_q    <= 8'h00;
      sec_q    <= 32'h0000_0000;
      line_q   <= 1'b0;
      xp_q     <= 1'b1;
      pend_q   <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      sb_q     <= sb_d;
      bc_q     <= bc_d;
      oa_q     <= oa_d;
      on_q     <= on_d;
      locked_q <= locked_d;
      held_q   <= held_d;
      ext_q    <= ext_d;
      sec_q    <= sec_d;
      line_q   <= line_d;
      xp_q     <= xp_d;
      pend_q   <= pend_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  // Per-byte valid bits: an unwritten byte reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[ram_waddr8[AddrW-1:0]] <= 1'b1;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_ready_i) begin
      if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc;
    end
  end

  // Output and skid words.
  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (in_acc) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/srtc_checker.sv */
// Port-level checker for the serial real-time clock block, bound to its top.
// Depends on srtc_pkg.
module srtc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input srtc_pkg::out_t out_data_o
);

  import srtc_pkg::*;

  // Input stalls only when a finished word is waiting at the output.
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no word at the output");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // An aborted transfer ends any read-out.
  a_abort_not_driving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fault_code == FAULT_ABORT) |-> !out_data_o.driving)
    else $error("still driving after an aborted transfer");

  // A seconds tick never reports a fault.
  a_pulse_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.second_pulse |-> (out_data_o.fault_code == FAULT_NONE))
    else $error("second pulse reported together with a fault");

endmodule

bind serial_rtc_with_parameter_ram_top srtc_checker u_srtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
